// ===== sv/assert_macros.svh =====
// Assertion macros for the modulation matrix router RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/mmr_pkg.sv =====
// Shared constants, types and helpers for the modulation matrix router.
// No dependencies.
package mmr_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SRC_COUNT = 4;
    localparam int SRC_AW    = 2;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 7;
    localparam int ROUTE_W  = 3;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int SCALE_W  = ACC_W - 6;

    localparam logic [15:0] HALF_Q15 = 16'd16384;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic [ROUTE_W-1:0]         route_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    typedef enum logic [3:0] {
        REG_ROUTE_LFO_A = 4'd0,
        REG_ROUTE_LFO_B = 4'd1,
        REG_ROUTE_ENV_A = 4'd2,
        REG_ROUTE_ENV_B = 4'd3,
        REG_GAIN_LFO_A  = 4'd4,
        REG_GAIN_LFO_B  = 4'd5,
        REG_GAIN_ENV_A  = 4'd6,
        REG_GAIN_ENV_B  = 4'd7
    } cfg_reg_t;

    function automatic logic slot_in_range(input logic [2:0] s);
        return int'(s) < NUM_SLOTS;
    endfunction

endpackage

// ===== sv/mmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/modulation_matrix_router_top.sv =====
// Modulation matrix router: top level with config registers, sequencer and datapath.
// Depends on mmr_pkg, mmr_ram and assert_macros.svh.
//
// Usage:
//   Input word (in_valid/in_stall): req_type 0 is a frame of four source samples,
//   req_type 1 applies the stored modulation of query_slot to base_value.
//   Output word (out_valid/out_stall): a frame gives one word per slot in slot
//   order, last set on the final one; an apply gives one word with last set.
//   Config (cfg_valid/cfg_ready): cfg_ready is always high; write only while idle.
// Timing:
//   Frame: the four sources in turn through the shared source multiplier, then one
//   slot per cycle as the output register frees. Apply: slot RAM read, multiply,
//   add. One item is in work at a time; the next one is taken while the final
//   word still waits in the output register.
// Reset: config clears to zero; per-slot valid flags clear so every slot reads
//   as zero until the first frame writes it. No clearing pass.
// Stall: a stalled output word holds; the sequencer waits on it.
`include "assert_macros.svh"

module modulation_matrix_router_top
    import mmr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic signed [15:0] lfo_a_sample,
    input  logic signed [15:0] lfo_b_sample,
    input  logic [14:0]        env_a_sample,
    input  logic [14:0]        env_b_sample,
    input  logic [2:0]         query_slot,
    input  logic [14:0]        base_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         slot_index,
    output logic signed [15:0] mod_value,
    output logic [14:0]        modulated_value,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SLOT,
        ST_AP_MUL,
        ST_AP_OUT
    } state_t;

    state_t                 state_reg;
    route_t                 route_reg [SRC_COUNT];
    gain_t                  gain_reg [SRC_COUNT];
    sample_t                src_reg [SRC_COUNT];
    prod_t                  prod_reg [SRC_COUNT];
    logic [SRC_AW-1:0]      src_cnt_reg;
    logic [SLOT_AW-1:0]     slot_cnt_reg;
    logic [NUM_SLOTS-1:0]   slot_valid_reg;
    logic [2:0]             q_reg;
    logic [14:0]            base_reg;
    logic signed [15:0]     mod_reg;
    logic signed [31:0]     ap_prod_reg;

    logic                   out_valid_reg;
    logic [2:0]             slot_index_reg;
    logic signed [15:0]     mod_value_reg;
    logic [14:0]            modulated_value_reg;
    logic                   last_reg;

    logic                   in_acc;
    logic                   out_free;
    logic                   out_load;
    logic                   slot_last;
    prod_t                  mul_out;
    logic signed [ACC_W-1:0] slot_acc;
    logic signed [SCALE_W-1:0] slot_scaled;
    logic signed [15:0]     slot_sat;
    logic signed [15:0]     ap_mod;
    logic signed [17:0]     ap_sum;
    logic [14:0]            ap_res;
    logic                   ram_we;
    logic                   ram_re;
    logic [15:0]            ram_rdata;

    localparam logic signed [SCALE_W-1:0] SAT_MAX = SCALE_W'(32767);
    localparam logic signed [SCALE_W-1:0] SAT_MIN = -SCALE_W'(32768);

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = ((state_reg == ST_SLOT) || (state_reg == ST_AP_OUT)) && out_free;
    assign slot_last = (slot_cnt_reg == SLOT_AW'(NUM_SLOTS - 1));
    assign cfg_ready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign slot_index      = slot_index_reg;
    assign mod_value       = mod_value_reg;
    assign modulated_value = modulated_value_reg;
    assign last            = last_reg;

    assign mul_out = src_reg[src_cnt_reg] * gain_reg[src_cnt_reg];

    always_comb
    begin
        slot_acc = '0;
        for (int i = 0; i < SRC_COUNT; i++)
        begin
            if (slot_in_range(route_reg[i]) && (SLOT_AW'(route_reg[i]) == slot_cnt_reg))
            begin
                slot_acc = slot_acc + ACC_W'(prod_reg[i]);
            end
        end
        slot_scaled = slot_acc[ACC_W-1:6];
        if (slot_scaled > SAT_MAX)
        begin
            slot_sat = 16'sh7fff;
        end
        else if (slot_scaled < SAT_MIN)
        begin
            slot_sat = -16'sh8000;
        end
        else
        begin
            slot_sat = slot_scaled[15:0];
        end
    end

    always_comb
    begin
        if (slot_in_range(q_reg) && slot_valid_reg[SLOT_AW'(q_reg)])
        begin
            ap_mod = ram_rdata;
        end
        else
        begin
            ap_mod = '0;
        end
        ap_sum = $signed({3'b000, base_reg}) + $signed({ap_prod_reg[31], ap_prod_reg[31:15]});
        if (ap_sum < 0)
        begin
            ap_res = '0;
        end
        else if (ap_sum > 18'sd32767)
        begin
            ap_res = 15'h7fff;
        end
        else
        begin
            ap_res = ap_sum[14:0];
        end
    end

    assign ram_we = (state_reg == ST_SLOT) && out_free;
    assign ram_re = in_acc && req_type;

    mmr_ram #(
        .WIDTH(16),
        .DEPTH(NUM_SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(slot_cnt_reg),
        .wdata(slot_sat),
        .re   (ram_re),
        .raddr(SLOT_AW'(query_slot)),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SRC_COUNT; i++)
            begin
                route_reg[i] <= '0;
                gain_reg[i]  <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROUTE_LFO_A: route_reg[0] <= cfg_data[2:0];
                REG_ROUTE_LFO_B: route_reg[1] <= cfg_data[2:0];
                REG_ROUTE_ENV_A: route_reg[2] <= cfg_data[2:0];
                REG_ROUTE_ENV_B: route_reg[3] <= cfg_data[2:0];
                REG_GAIN_LFO_A:  gain_reg[0]  <= cfg_data;
                REG_GAIN_LFO_B:  gain_reg[1]  <= cfg_data;
                REG_GAIN_ENV_A:  gain_reg[2]  <= cfg_data;
                REG_GAIN_ENV_B:  gain_reg[3]  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            src_cnt_reg         <= '0;
            slot_cnt_reg        <= '0;
            slot_valid_reg      <= '0;
            q_reg               <= '0;
            base_reg            <= '0;
            mod_reg             <= '0;
            ap_prod_reg         <= '0;
            out_valid_reg       <= 1'b0;
            slot_index_reg      <= '0;
            mod_value_reg       <= '0;
            modulated_value_reg <= '0;
            last_reg            <= 1'b0;
            for (int i = 0; i < SRC_COUNT; i++)
            begin
                src_reg[i]  <= '0;
                prod_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (req_type)
                        begin
                            q_reg     <= query_slot;
                            base_reg  <= base_value;
                            state_reg <= ST_AP_MUL;
                        end
                        else
                        begin
                            src_reg[0]  <= lfo_a_sample;
                            src_reg[1]  <= lfo_b_sample;
                            src_reg[2]  <= $signed({1'b0, env_a_sample} - HALF_Q15);
                            src_reg[3]  <= $signed({1'b0, env_b_sample} - HALF_Q15);
                            src_cnt_reg <= '0;
                            state_reg   <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod_reg[src_cnt_reg] <= mul_out;
                    src_cnt_reg           <= src_cnt_reg + 1'b1;
                    if (src_cnt_reg == SRC_AW'(SRC_COUNT - 1))
                    begin
                        slot_cnt_reg <= '0;
                        state_reg    <= ST_SLOT;
                    end
                end
                ST_SLOT:
                begin
                    if (out_free)
                    begin
                        slot_index_reg               <= 3'(slot_cnt_reg);
                        mod_value_reg                <= slot_sat;
                        modulated_value_reg          <= '0;
                        last_reg                     <= slot_last;
                        slot_valid_reg[slot_cnt_reg] <= 1'b1;
                        slot_cnt_reg                 <= slot_cnt_reg + 1'b1;
                        if (slot_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_AP_MUL:
                begin
                    mod_reg     <= ap_mod;
                    ap_prod_reg <= ap_mod * $signed({1'b0, base_reg});
                    state_reg   <= ST_AP_OUT;
                end
                ST_AP_OUT:
                begin
                    if (out_free)
                    begin
                        slot_index_reg      <= q_reg;
                        mod_value_reg       <= mod_reg;
                        modulated_value_reg <= ap_res;
                        last_reg            <= 1'b1;
                        state_reg           <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_frame_mid_zero, clk, rst_n, out_valid && !last, modulated_value == 15'd0)
    `ASSERT_NEXT(a_frame_fills_all, clk, rst_n, (state_reg == ST_SLOT) && out_free && slot_last, &slot_valid_reg)
    `ASSERT_IMPLIES(a_mul_start, clk, rst_n, state_reg == ST_IDLE, src_cnt_reg == '0)

endmodule
